### src/dcdf_pkg.sv
// ----------------------------------------------------------------------------
// dcdf_pkg
// Shared types and constants of the two-channel DDS DAC feeder.
// ----------------------------------------------------------------------------
package dcdf_pkg;

    localparam int PHASE_BITS  = 32;
    localparam int INDEX_BITS  = 8;
    localparam int SAMPLE_BITS = 12;
    localparam int WORD_BITS   = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    // Input item kinds.
    localparam logic [1:0] FUNC_TICK    = 2'd0;
    localparam logic [1:0] FUNC_LOAD    = 2'd1;
    localparam logic [1:0] FUNC_RESTART = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EN_A   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EN_B   = 2'd3;

    // Buffered reference, unity gain, active: always set in a command word.
    localparam logic [2:0] WORD_CTRL = 3'b111;

    typedef struct packed {
        logic [WORD_BITS-1:0] dac_word;
        logic                 chan;
        logic                 last;
    } out_item_t;

    typedef struct packed {
        logic first;
        logic second;
    } push_t;

endpackage

### src/dcdf_ram.sv
// ----------------------------------------------------------------------------
// dcdf_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dcdf_ram #(
    parameter int DATA_W = 12,
    parameter int ADDR_W = 8
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [1 << ADDR_W];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/dcdf_out_fifo.sv
// ----------------------------------------------------------------------------
// dcdf_out_fifo
// Small result queue that takes up to two words per cycle and sends one while the sink is ready.
// ----------------------------------------------------------------------------
module dcdf_out_fifo (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  dcdf_pkg::push_t                  push,
    input  dcdf_pkg::out_item_t              item0,
    input  dcdf_pkg::out_item_t              item1,
    output logic [dcdf_pkg::FIFO_CNT_W-1:0]  count,
    output logic                             out_valid,
    input  logic                             out_ready,
    output dcdf_pkg::out_item_t              out_item
);
    import dcdf_pkg::*;

    out_item_t               mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]   count_reg, count_next;
    logic                    pop;
    logic [FIFO_CNT_W-1:0]   push_n;

    assign pop       = out_valid && out_ready;
    assign push_n    = FIFO_CNT_W'(push.first) + FIFO_CNT_W'(push.second);
    assign out_valid = (count_reg != '0);
    assign out_item  = mem[rd_ptr_reg];
    assign count     = count_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        count_next  = count_reg + push_n - FIFO_CNT_W'(pop);
    end

    // The second slot is only used together with the first one.
    always_ff @(posedge aclk) begin
        if (push.first) begin
            mem[wr_ptr_reg] <= item0;
        end
        if (push.second) begin
            mem[wr_ptr_reg + FIFO_PTR_W'(1)] <= item1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### src/dual_channel_dds_dac_feeder.sv
// A tick's first DAC word is registered by the table read and pending flags, then by the queue.
// Throughput: one input transaction per cycle while the result queue has room;
// a tick with both channels enabled emits two words over the single output
// port, so that port limits how often such ticks can be taken.
// Reset: aresetn is synchronous and active low; it clears phases, registers
// and the result queue. Waveform tables are not cleared and must be loaded.
// ----------------------------------------------------------------------------
// dual_channel_dds_dac_feeder
// Two-channel DDS phase accumulator with waveform tables feeding DAC words.
// ----------------------------------------------------------------------------
module dual_channel_dds_dac_feeder (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [23:0]                       s_tdata,  // table_index, sample_value
    input  logic [2:0]                        s_tuser,  // func, channel
    // Result stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [15:0]                       m_tdata,  // dac_word
    output logic [0:0]                        m_tuser,  // out_channel
    output logic                              m_tlast,
    // Configuration write channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dcdf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dcdf_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import dcdf_pkg::*;

    logic [1:0]             in_func;
    logic                   in_chan;
    logic [INDEX_BITS-1:0]  in_index;
    logic [SAMPLE_BITS-1:0] in_sample;
    logic                   accept, tick, load, restart;

    logic [PHASE_BITS-1:0]  step_a_reg, step_b_reg;
    logic                   en_a_reg, en_b_reg;
    logic [PHASE_BITS-1:0]  phase_a_reg, phase_a_next;
    logic [PHASE_BITS-1:0]  phase_b_reg, phase_b_next;

    logic                   pend_a_reg, pend_a_next;
    logic                   pend_b_reg, pend_b_next;
    logic [1:0]             pend_n;

    logic [SAMPLE_BITS-1:0] rd_a, rd_b;
    push_t                  push;
    out_item_t              item_a, item_b, item0, item1, out_item;
    logic [FIFO_CNT_W-1:0]  fifo_count;

    assign in_func   = s_tuser[1:0];
    assign in_chan   = s_tuser[2];
    assign in_index  = s_tdata[INDEX_BITS-1:0];
    assign in_sample = s_tdata[8 +: SAMPLE_BITS];

    // Room for the words still in flight plus two more from a new tick.
    assign pend_n   = 2'(pend_a_reg) + 2'(pend_b_reg);
    assign s_tready = ((FIFO_CNT_W + 1)'(fifo_count) + (FIFO_CNT_W + 1)'(pend_n))
                      <= (FIFO_CNT_W + 1)'(FIFO_DEPTH - 2);
    assign accept   = s_tvalid && s_tready;
    assign tick     = accept && (in_func == FUNC_TICK);
    assign load     = accept && (in_func == FUNC_LOAD);
    assign restart  = accept && (in_func == FUNC_RESTART);

    assign cfg_ready = 1'b1;

    // Tables are read every cycle at the current phase; the data lines up
    // with the pending flags set by the tick that used that phase.
    dcdf_ram #(.DATA_W(SAMPLE_BITS), .ADDR_W(INDEX_BITS)) u_table_a (
        .aclk  (aclk),
        .we    (load && !in_chan),
        .waddr (in_index),
        .wdata (in_sample),
        .raddr (phase_a_reg[PHASE_BITS-1 -: INDEX_BITS]),
        .rdata (rd_a)
    );

    dcdf_ram #(.DATA_W(SAMPLE_BITS), .ADDR_W(INDEX_BITS)) u_table_b (
        .aclk  (aclk),
        .we    (load && in_chan),
        .waddr (in_index),
        .wdata (in_sample),
        .raddr (phase_b_reg[PHASE_BITS-1 -: INDEX_BITS]),
        .rdata (rd_b)
    );

    always_comb begin
        phase_a_next = phase_a_reg;
        phase_b_next = phase_b_reg;
        pend_a_next  = tick && en_a_reg;
        pend_b_next  = tick && en_b_reg;
        if (restart) begin
            phase_a_next = '0;
            phase_b_next = '0;
        end else if (tick) begin
            if (en_a_reg) begin
                phase_a_next = phase_a_reg + step_a_reg;
            end
            if (en_b_reg) begin
                phase_b_next = phase_b_reg + step_b_reg;
            end
        end
    end

    always_comb begin
        item_a.dac_word = {1'b0, WORD_CTRL, rd_a};
        item_a.chan     = 1'b0;
        item_a.last     = !pend_b_reg;
        item_b.dac_word = {1'b1, WORD_CTRL, rd_b};
        item_b.chan     = 1'b1;
        item_b.last     = 1'b1;
        item0           = pend_a_reg ? item_a : item_b;
        item1           = item_b;
        push.first      = pend_a_reg || pend_b_reg;
        push.second     = pend_a_reg && pend_b_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_a_reg  <= '0;
            step_b_reg  <= '0;
            en_a_reg    <= 1'b0;
            en_b_reg    <= 1'b0;
            phase_a_reg <= '0;
            phase_b_reg <= '0;
            pend_a_reg  <= 1'b0;
            pend_b_reg  <= 1'b0;
        end else begin
            phase_a_reg <= phase_a_next;
            phase_b_reg <= phase_b_next;
            pend_a_reg  <= pend_a_next;
            pend_b_reg  <= pend_b_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_STEP_A: step_a_reg <= cfg_data[PHASE_BITS-1:0];
                    CFG_STEP_B: step_b_reg <= cfg_data[PHASE_BITS-1:0];
                    CFG_EN_A:   en_a_reg   <= cfg_data[0];
                    CFG_EN_B:   en_b_reg   <= cfg_data[0];
                    default:    ;
                endcase
            end
        end
    end

    dcdf_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .item0     (item0),
        .item1     (item1),
        .count     (fifo_count),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    assign m_tdata = out_item.dac_word;
    assign m_tuser = out_item.chan;
    assign m_tlast = out_item.last;

endmodule

### src/dcdf_checker.sv
// ----------------------------------------------------------------------------
// dcdf_checker
// Port-level checks on the result stream of the DDS DAC feeder.
// ----------------------------------------------------------------------------
module dcdf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        m_tlast
);

    // A stalled word must hold until the sink takes it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    // Buffer, gain and shutdown control bits are always set.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[14:12] == 3'b111)
        else $error("DAC control bits not set");

    // The channel-select bit of the command word follows the channel tag.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15] == m_tuser[0])
        else $error("channel bit disagrees with channel tag");

    // Channel B is always the final word of its tick.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("channel B word not marked last");

endmodule

bind dual_channel_dds_dac_feeder dcdf_checker u_dcdf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
